// ----- rtl/b64d_pkg.sv -----
// shared types, constants and decode functions for the base64 descrambler
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int KEY_LENGTH = 128;
    localparam int POS_W      = $clog2(KEY_LENGTH);
    localparam int KEY_IDX_W  = 7;
    localparam int KEY_BYTES  = 1 << KEY_IDX_W;
    localparam int GROUP_OUT  = 3;

    // masks used to split sextets across byte boundaries
    localparam logic [5:0] MASK_S1_HI = 6'h30;
    localparam logic [5:0] MASK_S2_HI = 6'h3c;
    localparam logic [5:0] MASK_S1_LO = 6'h0f;
    localparam logic [5:0] MASK_S2_LO = 6'h03;

    localparam logic [8*KEY_BYTES-1:0] KEY_ROM = {
        "2V:-5?Vl%ulG+4-PG0`#:;[DUnB.Qs::",
        "v<{#]_oaa3NWyGtA[bq>Qf<i,28gV,,;",
        "y;W6rzn)ij}Ol%Eaxoq),+tx>l|@BS($",
        "7W9b9|46Fr&%pS!}[>5g5lly|bC]3aQu"
    };

    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_item;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    typedef struct packed {
        logic [GROUP_OUT-1:0][7:0] bytes;
        logic [1:0]                count;
        logic                      data_ok;
        logic                      fin;
    } t_bundle;

    function automatic t_sextet char_to_sextet(input logic [7:0] c);
        t_sextet s;
        s.ok  = 1'b1;
        s.val = 6'd0;
        priority if (c >= "A" && c <= "Z") begin
            s.val = 6'(c - 8'("A"));
        end else if (c >= "a" && c <= "z") begin
            s.val = 6'(c - 8'("a") + 8'd26);
        end else if (c >= "0" && c <= "9") begin
            s.val = 6'(c - 8'("0") + 8'd52);
        end else if (c == "+") begin
            s.val = 6'd62;
        end else if (c == "/") begin
            s.val = 6'd63;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

    function automatic logic [GROUP_OUT-1:0][7:0] group_bytes(
        input logic [5:0] s0,
        input logic [5:0] s1,
        input logic [5:0] s2,
        input logic [5:0] s3
    );
        logic [GROUP_OUT-1:0][7:0] b;
        b[0] = {s0, 2'((s1 & MASK_S1_HI) >> 4)};
        b[1] = {4'(s1 & MASK_S1_LO), 4'((s2 & MASK_S2_HI) >> 2)};
        b[2] = {2'(s2 & MASK_S2_LO), s3};
        return b;
    endfunction

    function automatic logic [7:0] key_byte(input logic [KEY_IDX_W-1:0] idx);
        return KEY_ROM[8*(KEY_BYTES-1-int'(idx)) +: 8];
    endfunction

    // position advance modulo the key length, k stays below the key length
    function automatic t_pos pos_add(input t_pos pos, input logic [1:0] k);
        logic [POS_W:0] sum;
        sum = {1'b0, pos} + (POS_W+1)'(k);
        if (sum >= (POS_W+1)'(KEY_LENGTH)) begin
            sum = sum - (POS_W+1)'(KEY_LENGTH);
        end
        return POS_W'(sum);
    endfunction

endpackage

// ----- rtl/base64_decode_xor_descramble_unit.sv -----
// top level of the base64 decoder with repeating key descrambling
//
//  port group  dir  tdata             tuser         tlast
//  s_axis      in   [7:0] character   -             end of string
//  m_axis      out  [7:0] data byte   [0] byte ok   last byte of string
//
// a character a cycle unless the output is busy; four give three bytes, a beat each
// the character register holds one beat while the byte register drains its bundle
// a beat with no bytes passes even while bytes are still pending at the output
// reset is synchronous and active low, clears group state and key position
// a stall on m_axis holds o_m_axis_* and backs up into s_axis once the bundle is full
`timescale 1ns / 1ps

module base64_decode_xor_descramble_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_char
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tuser,   // [0] byte_valid
    output logic       o_m_axis_tlast
);

    b64d_pkg::t_item   in_item;
    b64d_pkg::t_item   cur_item;
    b64d_pkg::t_bundle bundle;
    logic              cur_valid;
    logic              take;
    logic              bundle_valid;
    logic              bundle_ready;

    assign in_item.ch   = i_s_axis_tdata;
    assign in_item.last = i_s_axis_tlast;

    b64d_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_item  (in_item),
        .o_ready (o_s_axis_tready),
        .o_valid (cur_valid),
        .o_item  (cur_item),
        .i_take  (take)
    );

    b64d_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (cur_valid),
        .i_item         (cur_item),
        .o_take         (take),
        .o_bundle_valid (bundle_valid),
        .o_bundle       (bundle),
        .i_bundle_ready (bundle_ready)
    );

    b64d_out_ser u_out_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bundle_valid (bundle_valid),
        .i_bundle       (bundle),
        .o_bundle_ready (bundle_ready),
        .o_valid        (o_m_axis_tvalid),
        .o_byte         (o_m_axis_tdata),
        .o_byte_valid   (o_m_axis_tuser),
        .o_last         (o_m_axis_tlast),
        .i_ready        (i_m_axis_tready)
    );

endmodule

// ----- rtl/b64d_in_reg.sv -----
// input register stage for character beats
`timescale 1ns / 1ps

module b64d_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  b64d_pkg::t_item    i_item,
    output logic               o_ready,
    output logic               o_valid,
    output b64d_pkg::t_item    o_item,
    input  logic               i_take
);

    logic            r_valid;
    b64d_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- rtl/b64d_core.sv -----
// group assembly, flush and key xor for one character per cycle, unless a bundle waits on the output
`timescale 1ns / 1ps

module b64d_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  b64d_pkg::t_item    i_item,
    output logic               o_take,
    output logic               o_bundle_valid,
    output b64d_pkg::t_bundle  o_bundle,
    input  logic               i_bundle_ready
);

    logic [2:0][5:0]  r_buf;
    logic [1:0]       r_fill;
    logic             r_halted;
    b64d_pkg::t_pos   r_pos;

    logic [2:0][5:0]  n_buf;
    logic [1:0]       n_fill;
    logic             n_halted;
    b64d_pkg::t_pos   n_pos;

    b64d_pkg::t_sextet                      sx;
    logic                                   grp;
    logic                                   flush;
    logic [5:0]                             s0, s1, s2, s3;
    logic [b64d_pkg::GROUP_OUT-1:0][7:0]    raw;
    logic [1:0]                             count;
    b64d_pkg::t_pos                         kpos [b64d_pkg::GROUP_OUT];

    always_comb begin
        sx       = b64d_pkg::char_to_sextet(i_item.ch);
        n_buf    = r_buf;
        n_fill   = r_fill;
        n_halted = r_halted;
        grp      = 1'b0;
        if (!r_halted) begin
            if (!sx.ok) begin
                n_halted = 1'b1;
            end else begin
                unique case (r_fill)
                    2'd0: begin
                        n_buf[0] = sx.val;
                        n_fill   = 2'd1;
                    end
                    2'd1: begin
                        n_buf[1] = sx.val;
                        n_fill   = 2'd2;
                    end
                    2'd2: begin
                        n_buf[2] = sx.val;
                        n_fill   = 2'd3;
                    end
                    default: begin
                        grp    = 1'b1;
                        n_fill = 2'd0;
                    end
                endcase
            end
        end

        flush = i_item.last && (n_fill >= 2'd2);

        // flush pads the missing sextets with zero
        if (grp) begin
            s0 = r_buf[0];
            s1 = r_buf[1];
            s2 = r_buf[2];
            s3 = sx.val;
        end else begin
            s0 = n_buf[0];
            s1 = n_buf[1];
            s2 = (n_fill == 2'd3) ? n_buf[2] : 6'd0;
            s3 = 6'd0;
        end
        raw = b64d_pkg::group_bytes(s0, s1, s2, s3);

        priority if (grp) begin
            count = 2'd3;
        end else if (flush) begin
            count = n_fill - 2'd1;
        end else if (i_item.last) begin
            count = 2'd1;
        end else begin
            count = 2'd0;
        end

        kpos[0] = r_pos;
        kpos[1] = b64d_pkg::pos_add(r_pos, 2'd1);
        kpos[2] = b64d_pkg::pos_add(r_pos, 2'd2);

        o_bundle.count   = count;
        o_bundle.data_ok = grp || flush;
        o_bundle.fin     = i_item.last;
        for (int j = 0; j < b64d_pkg::GROUP_OUT; j++) begin
            o_bundle.bytes[j] = (grp || flush)
                ? (raw[j] ^ b64d_pkg::key_byte(b64d_pkg::KEY_IDX_W'(kpos[j])))
                : 8'd0;
        end

        n_pos = grp ? b64d_pkg::pos_add(r_pos, 2'd3) : r_pos;
    end

    assign o_bundle_valid = i_valid && (count != 2'd0);
    assign o_take         = i_valid && ((count == 2'd0) || i_bundle_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf    <= '0;
            r_fill   <= 2'd0;
            r_halted <= 1'b0;
            r_pos    <= '0;
        end else if (o_take) begin
            if (i_item.last) begin
                r_buf    <= '0;
                r_fill   <= 2'd0;
                r_halted <= 1'b0;
                r_pos    <= '0;
            end else begin
                r_buf    <= n_buf;
                r_fill   <= n_fill;
                r_halted <= n_halted;
                r_pos    <= n_pos;
            end
        end
    end

    a_bundle_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bundle_valid |-> (o_bundle.count != 2'd0))
        else $error("bundle offered with no bytes");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_halted && !i_item.last) |-> !o_bundle_valid)
        else $error("result after stop character");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.last) |=> (r_fill == 2'd0 && !r_halted && r_pos == '0))
        else $error("state not cleared after end of string");

endmodule

// ----- rtl/b64d_out_ser.sv -----
// result register that hands out a bundle of up to three bytes one beat at a time
`timescale 1ns / 1ps

module b64d_out_ser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_bundle_valid,
    input  b64d_pkg::t_bundle  i_bundle,
    output logic               o_bundle_ready,
    output logic               o_valid,
    output logic [7:0]         o_byte,
    output logic               o_byte_valid,
    output logic               o_last,
    input  logic               i_ready
);

    logic [b64d_pkg::GROUP_OUT-1:0][7:0] r_bytes;
    logic [1:0]                          r_left;
    logic [1:0]                          r_idx;
    logic                                r_data_ok;
    logic                                r_fin;

    logic beat;

    assign o_valid        = (r_left != 2'd0);
    assign beat           = o_valid && i_ready;
    assign o_bundle_ready = (r_left == 2'd0) || (r_left == 2'd1 && i_ready);
    assign o_byte_valid   = r_data_ok;
    assign o_last         = r_fin && (r_left == 2'd1);

    always_comb begin
        unique case (r_idx)
            2'd0:    o_byte = r_bytes[0];
            2'd1:    o_byte = r_bytes[1];
            default: o_byte = r_bytes[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
            r_idx  <= 2'd0;
        end else if (i_bundle_valid && o_bundle_ready) begin
            r_left <= i_bundle.count;
            r_idx  <= 2'd0;
        end else if (beat) begin
            r_left <= r_left - 2'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bundle_valid && o_bundle_ready) begin
            r_bytes   <= i_bundle.bytes;
            r_data_ok <= i_bundle.data_ok;
            r_fin     <= i_bundle.fin;
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the base64 decoder with repeating key descrambling
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] data;
    logic       ok;
    logic       fin;
} t_byte_beat;

class descramble_scoreboard;
    logic [5:0]  held [3];
    int unsigned fill;
    bit          halted;
    int unsigned pos;
    t_byte_beat  due [$];
    int unsigned mismatches;

    function new();
        mismatches = 0;
        clear_state();
    endfunction

    function void clear_state();
        foreach (held[i]) held[i] = 6'd0;
        fill   = 0;
        halted = 1'b0;
        pos    = 0;
    endfunction

    function int unsigned pending();
        return due.size();
    endfunction

    // returns 1 with the sextet value for an alphabet character
    function bit sextet_of(input logic [7:0] ch, output logic [5:0] v);
        v = 6'd0;
        if (ch >= "A" && ch <= "Z") v = 6'(ch - "A");
        else if (ch >= "a" && ch <= "z") v = 6'(ch - "a" + 26);
        else if (ch >= "0" && ch <= "9") v = 6'(ch - "0" + 52);
        else if (ch == "+") v = 6'd62;
        else if (ch == "/") v = 6'd63;
        else return 1'b0;
        return 1'b1;
    endfunction

    function logic [7:0] key_at(input int unsigned p);
        int unsigned idx;
        idx = (p % b64d_pkg::KEY_LENGTH) % b64d_pkg::KEY_BYTES;
        return b64d_pkg::KEY_ROM[8*(b64d_pkg::KEY_BYTES-1-idx) +: 8];
    endfunction

    function void push_byte(input logic [7:0] raw);
        t_byte_beat e;
        e.data = raw ^ key_at(pos);
        e.ok   = 1'b1;
        e.fin  = 1'b0;
        due.push_back(e);
        pos = (pos + 1) % b64d_pkg::KEY_LENGTH;
    endfunction

    function void push_group(input logic [5:0] s0, input logic [5:0] s1,
                             input logic [5:0] s2, input logic [5:0] s3,
                             input int unsigned count);
        logic [7:0] b [3];
        b[0] = {s0, s1[5:4]};
        b[1] = {s1[3:0], s2[5:2]};
        b[2] = {s2[1:0], s3};
        for (int i = 0; i < count; i++) push_byte(b[i]);
    endfunction

    function void note_char(input logic [7:0] ch, input logic last);
        logic [5:0]  v;
        int unsigned before_cnt;
        t_byte_beat  e;
        before_cnt = due.size();
        if (!halted) begin
            if (!sextet_of(ch, v)) begin
                halted = 1'b1;
            end else if (fill == 3) begin
                push_group(held[0], held[1], held[2], v, 3);
                fill = 0;
            end else begin
                held[fill] = v;
                fill++;
            end
        end
        if (!last) return;
        // partial group: missing sextets read as zero
        if (fill >= 2) begin
            push_group(held[0], held[1], fill == 3 ? held[2] : 6'd0, 6'd0, fill - 1);
        end
        if (due.size() == before_cnt) begin
            e.data = 8'h00;
            e.ok   = 1'b0;
            e.fin  = 1'b1;
            due.push_back(e);
        end else begin
            e = due.pop_back();
            e.fin = 1'b1;
            due.push_back(e);
        end
        clear_state();
    endfunction

    function void check_beat(input logic [7:0] data, input logic ok, input logic fin);
        t_byte_beat e;
        if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected beat: data=%02h ok=%b last=%b", data, ok, fin);
            return;
        end
        e = due.pop_front();
        if (data !== e.data || ok !== e.ok || fin !== e.fin) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected data=%02h ok=%b last=%b, got data=%02h ok=%b last=%b",
                         e.data, e.ok, e.fin, data, ok, fin);
        end
    endfunction
endclass

module tb_top;
    localparam int ITEMS       = 380;
    localparam int LONG_CHARS  = 176;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data = 8'h00;
    logic       s_last = 1'b0;
    logic       m_ready = 1'b0;
    wire        s_ready;
    wire        m_valid;
    wire  [7:0] m_data;
    wire        m_user;
    wire        m_last;

    descramble_scoreboard sb = new();
    int unsigned n_sent = 0;
    int unsigned quiet = 0;
    bit          steady = 1'b0;
    bit          hold = 1'b0;

    base64_decode_xor_descramble_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [7:0] in_char
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [7:0] out_byte
        .o_m_axis_tuser  (m_user),   // [0] byte_valid
        .o_m_axis_tlast  (m_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_char(input logic [7:0] ch, input logic last);
        while (!steady && $urandom_range(0, 99) < 29) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= ch;
        s_last  <= last;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sb.note_char(ch, last);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
    endtask

    function automatic logic [7:0] alpha_char();
        return B64_ALPHABET[$urandom_range(0, 63)];
    endfunction

    initial begin
        int unsigned len;
        int unsigned kind;
        int unsigned pad;
        int unsigned stop_at;
        logic [7:0]  ch;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed strings
        send_char(8'h00, 1'b1);
        send_text("=");
        send_text("A");
        send_text("AZ");
        send_text("az0");
        send_text("9+/A");
        send_text("QUJD=");
        send_char("Q", 1'b0);
        send_char(8'hff, 1'b0);
        send_char("x", 1'b0);
        send_char("y", 1'b1);

        // long string so the key position wraps
        for (int i = 0; i < LONG_CHARS; i++) send_char(alpha_char(), i == LONG_CHARS - 1);

        while (n_sent < ITEMS) begin
            len     = $urandom_range(1, 24);
            kind    = $urandom_range(0, 99);
            pad     = $urandom_range(0, 2);
            stop_at = $urandom_range(0, len - 1);
            steady  = (n_sent >= 240 && n_sent < 310);
            for (int i = 0; i < len; i++) begin
                if (kind < 70) begin
                    ch = (i + pad >= len) ? 8'("=") : alpha_char();
                end else if (kind < 85) begin
                    if (i < stop_at) ch = alpha_char();
                    else if (i == stop_at) ch = $urandom_range(0, 1) ? 8'("=")
                                                                     : 8'($urandom_range(0, 255));
                    else ch = 8'($urandom_range(0, 255));
                end else begin
                    ch = 8'($urandom_range(0, 255));
                end
                send_char(ch, i == len - 1);
            end
        end
        steady  = 1'b0;
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** base64_decode_xor_descramble_unit: PASSED **");
        end else begin
            $display("** base64_decode_xor_descramble_unit: FAILED **");
        end
        $finish;
    end

    // output side: random stalls, plus the long hold-off
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            m_ready <= !hold && (steady || $urandom_range(0, 99) >= 29);
            @(posedge i_clk);
            if (m_valid && m_ready) sb.check_beat(m_data, m_user, m_last);
        end
    end

    // stall the output long enough for the block to back up into its input
    initial begin
        wait (n_sent >= 60);
        hold = 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
        hold = 1'b0;
    end

    initial begin
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("** base64_decode_xor_descramble_unit: FAILED **");
        $finish;
    end
endmodule
